// ----- rtl/assert_macros.svh -----
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define PPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define PPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ppc_pkg.sv -----
`default_nettype none
package ppc_pkg;
   localparam int POOL_DEPTH = 1024;
   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int REM_BITS_PER_CYCLE = 4;
   localparam int REM_CYCLES = 64 / REM_BITS_PER_CYCLE;
   localparam int REM_CNT_W = $clog2(REM_CYCLES);

   localparam logic [63:0] DEFAULT_SEED = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] XS_MULT = 64'd2685821657736338717;
   localparam int XS_SHIFT_A = 12;
   localparam int XS_SHIFT_B = 25;
   localparam int XS_SHIFT_C = 27;

   localparam logic OP_BUILD = 1'b0;
   localparam logic OP_CHASE = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_SEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 2'd1;
   localparam logic [10:0] NODE_COUNT_RESET = 11'd1024;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  start_index;
      logic        start_is_null;
      logic [23:0] hop_count;
   } req_type;

   typedef struct packed {
      logic [9:0] end_index;
      logic       status;
      logic       was_build;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [63:0]      dividend;
      logic [CNT_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] rem;
   } rem_rsp_type;

   typedef struct packed {
      logic        load;
      logic [63:0] seed;
      logic        step;
   } rng_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } rng_out_type;
endpackage
`default_nettype wire

// ----- rtl/ppc_rem.sv -----
`default_nettype none
module ppc_rem (
   input  wire                 clock,
   input  wire                 reset,
   input  ppc_pkg::rem_req_type req,
   output ppc_pkg::rem_rsp_type rsp
);
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [ppc_pkg::REM_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [63:0]                         dvd_ff, dvd_in;
   logic [ppc_pkg::CNT_W-1:0]           div_ff, div_in;
   logic [ppc_pkg::CNT_W-1:0]           rem_ff, rem_in;
   logic [ppc_pkg::CNT_W-1:0]           step_rem;
   logic [ppc_pkg::CNT_W:0]             trial;

   always_comb begin
      step_rem = rem_ff;
      trial = '0;
      for (int k = 0; k < ppc_pkg::REM_BITS_PER_CYCLE; k++) begin
         trial = {step_rem, dvd_ff[63 - k]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         step_rem = trial[ppc_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dvd_in = req.dividend;
         div_in = req.divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         rem_in = step_rem;
         dvd_in = dvd_ff << ppc_pkg::REM_BITS_PER_CYCLE;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ppc_pkg::REM_CNT_W'(ppc_pkg::REM_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem = rem_ff;
endmodule
`default_nettype wire

// ----- rtl/ppc_rng.sv -----
`default_nettype none
module ppc_rng (
   input  wire                  clock,
   input  wire                  reset,
   input  ppc_pkg::rng_ctrl_type ctrl,
   output ppc_pkg::rng_out_type  out
);
   logic [63:0] state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] hi_ff, hi_in;
   logic [63:0] xs1, xs2, xs3;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   always_comb begin
      xs1 = state_ff ^ (state_ff >> ppc_pkg::XS_SHIFT_A);
      xs2 = xs1 ^ (xs1 << ppc_pkg::XS_SHIFT_B);
      xs3 = xs2 ^ (xs2 >> ppc_pkg::XS_SHIFT_C);
   end

   always_comb begin
      case (phase_ff)
         3'd2: begin
            mul_a = state_ff[63:32];
            mul_b = ppc_pkg::XS_MULT[31:0];
         end
         3'd3: begin
            mul_a = state_ff[31:0];
            mul_b = ppc_pkg::XS_MULT[63:32];
         end
         default: begin
            mul_a = state_ff[31:0];
            mul_b = ppc_pkg::XS_MULT[31:0];
         end
      endcase
      prod = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      acc_in = acc_ff;
      hi_in = hi_ff;
      case (phase_ff)
         3'd0: begin
            if (ctrl.load) begin
               state_in = ctrl.seed;
            end else if (ctrl.step) begin
               state_in = xs3;
               phase_in = 3'd1;
            end
         end
         3'd1: begin
            acc_in = prod;
            phase_in = 3'd2;
         end
         3'd2: begin
            hi_in = prod[31:0];
            phase_in = 3'd3;
         end
         3'd3: begin
            hi_in = hi_ff + prod[31:0];
            phase_in = 3'd4;
         end
         3'd4: begin
            phase_in = 3'd0;
         end
         default: begin
            phase_in = 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      acc_ff <= acc_in;
      hi_ff <= hi_in;
   end

   assign out.done = (phase_ff == 3'd4);
   assign out.value = acc_ff + {hi_ff, 32'd0};
endmodule
`default_nettype wire

// ----- rtl/permutation_pool_pointer_chaser.sv -----
// Permutation pool pointer chaser.
// Requests arrive on req_valid/req_ready with a req_type payload; one result
// per request leaves on rsp_valid/rsp_ready with a rsp_type payload.
// Configuration registers (seed, node_count) are written through csr_we,
// csr_index and csr_wdata; the user must write them only while idle, and the
// block itself does not enforce this. A build request initializes the order
// memory, shuffles it with n-1 rounds (each runs the generator, the 64-bit
// remainder unit, then one read and two writes), then links the order into
// the next-pointer memory. A chase request first reduces hop_count modulo
// the pool size, then does one read per hop through the next-pointer
// memory. Errors go straight to the output state.
// One request is in flight at a time; req_ready is high only when idle.
// The result sits in an output register; a stalled receiver holds it there,
// and a finished request waits until that register is free.
// Reset is synchronous; it clears the control state, drops any pool and
// restores the registers. The memories need no clearing.
`default_nettype none
module permutation_pool_pointer_chaser (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  ppc_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output ppc_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_we,
   input  wire [ppc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [63:0]                           csr_wdata
);
   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_INIT   = 14'b00000000000010,
      ST_SH_RNG = 14'b00000000000100,
      ST_SH_GEN = 14'b00000000001000,
      ST_SH_REM = 14'b00000000010000,
      ST_SH_RD  = 14'b00000000100000,
      ST_SH_WR1 = 14'b00000001000000,
      ST_SH_WR2 = 14'b00000010000000,
      ST_LK_RD  = 14'b00000100000000,
      ST_LK_WR  = 14'b00001000000000,
      ST_CH_MOD = 14'b00010000000000,
      ST_CH_RD  = 14'b00100000000000,
      ST_CH_WT  = 14'b01000000000000,
      ST_OUT    = 14'b10000000000000
   } state_type;

   localparam int IW = ppc_pkg::IDX_W;
   localparam int CW = ppc_pkg::CNT_W;

   state_type            state_ff, state_in;
   logic [63:0]          seed_ff, seed_in;
   logic [CW-1:0]        count_cfg_ff, count_cfg_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        built_ff, built_in;
   logic                 pool_ff, pool_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        j_ff, j_in;
   logic [IW-1:0]        tmp_ff, tmp_in;
   logic [IW-1:0]        p_ff, p_in;
   logic [CW-1:0]        hops_ff, hops_in;
   ppc_pkg::rsp_type     pend_ff, pend_in;
   ppc_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]        ord_mem [ppc_pkg::POOL_DEPTH];
   logic [IW-1:0]        nxt_mem [ppc_pkg::POOL_DEPTH];
   logic [IW-1:0]        ord_rda_ff, ord_rdb_ff, nxt_rd_ff;
   logic [IW-1:0]        ord_ra, ord_rb, ord_wa, ord_wd, nxt_wa, nxt_wd;
   logic                 ord_we, nxt_we;
   logic [IW-1:0]        link_nx;
   logic [CW-1:0]        n_sat;
   logic                 chase_err;

   ppc_pkg::rem_req_type rem_req;
   ppc_pkg::rem_rsp_type rem_rsp;
   ppc_pkg::rng_ctrl_type rng_ctrl;
   ppc_pkg::rng_out_type  rng_out;

   ppc_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   ppc_rng u_rng (
      .clock (clock),
      .reset (reset),
      .ctrl  (rng_ctrl),
      .out   (rng_out)
   );

   always_comb begin
      seed_in = seed_ff;
      count_cfg_in = count_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ppc_pkg::REG_SEED: seed_in = csr_wdata;
            ppc_pkg::REG_NODE_COUNT: count_cfg_in = csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign n_sat = (count_cfg_ff > CW'(ppc_pkg::POOL_DEPTH)) ?
                  CW'(ppc_pkg::POOL_DEPTH) : count_cfg_ff;
   assign link_nx = ({1'b0, idx_ff} + 1'b1 == n_ff) ? '0 : idx_ff + 1'b1;
   assign chase_err = req_data.start_is_null || !pool_ff || (built_ff == '0) ||
                      ({1'b0, req_data.start_index} >= built_ff);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      built_in = built_ff;
      pool_in = pool_ff;
      idx_in = idx_ff;
      j_in = j_ff;
      tmp_in = tmp_ff;
      p_in = p_ff;
      hops_in = hops_ff;
      pend_in = pend_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ord_ra = idx_ff;
      ord_rb = (state_ff == ST_LK_RD) ? link_nx : j_ff;
      ord_we = 1'b0;
      ord_wa = idx_ff;
      ord_wd = idx_ff;
      nxt_we = 1'b0;
      nxt_wa = ord_rda_ff;
      nxt_wd = ord_rdb_ff;
      rem_req.start = 1'b0;
      rem_req.dividend = {40'd0, req_data.hop_count};
      rem_req.divisor = built_ff;
      rng_ctrl.load = 1'b0;
      rng_ctrl.seed = (seed_ff == '0) ? ppc_pkg::DEFAULT_SEED : seed_ff;
      rng_ctrl.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_in = '0;
               if (req_data.opcode == ppc_pkg::OP_BUILD) begin
                  pend_in.was_build = 1'b1;
                  if (n_sat == '0) begin
                     pool_in = 1'b0;
                     built_in = '0;
                     pend_in.status = ppc_pkg::STATUS_ERR;
                     state_in = ST_OUT;
                  end else begin
                     n_in = n_sat;
                     idx_in = '0;
                     rng_ctrl.load = 1'b1;
                     state_in = ST_INIT;
                  end
               end else if (chase_err) begin
                  pend_in.status = ppc_pkg::STATUS_ERR;
                  state_in = ST_OUT;
               end else begin
                  p_in = req_data.start_index;
                  rem_req.start = 1'b1;
                  state_in = ST_CH_MOD;
               end
            end
         end
         ST_INIT: begin
            ord_we = 1'b1;
            if ({1'b0, idx_ff} + 1'b1 == n_ff) begin
               if (n_ff == CW'(1)) begin
                  idx_in = '0;
                  state_in = ST_LK_RD;
               end else begin
                  state_in = ST_SH_RNG;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SH_RNG: begin
            rng_ctrl.step = 1'b1;
            state_in = ST_SH_GEN;
         end
         ST_SH_GEN: begin
            if (rng_out.done) begin
               rem_req.start = 1'b1;
               rem_req.dividend = rng_out.value;
               rem_req.divisor = {1'b0, idx_ff} + 1'b1;
               state_in = ST_SH_REM;
            end
         end
         ST_SH_REM: begin
            if (rem_rsp.done) begin
               j_in = rem_rsp.rem[IW-1:0];
               state_in = ST_SH_RD;
            end
         end
         ST_SH_RD: begin
            state_in = ST_SH_WR1;
         end
         ST_SH_WR1: begin
            tmp_in = ord_rda_ff;
            ord_we = 1'b1;
            ord_wa = idx_ff;
            ord_wd = ord_rdb_ff;
            state_in = ST_SH_WR2;
         end
         ST_SH_WR2: begin
            ord_we = 1'b1;
            ord_wa = j_ff;
            ord_wd = tmp_ff;
            if (idx_ff == IW'(1)) begin
               idx_in = '0;
               state_in = ST_LK_RD;
            end else begin
               idx_in = idx_ff - 1'b1;
               state_in = ST_SH_RNG;
            end
         end
         ST_LK_RD: begin
            state_in = ST_LK_WR;
         end
         ST_LK_WR: begin
            nxt_we = 1'b1;
            if ({1'b0, idx_ff} + 1'b1 == n_ff) begin
               built_in = n_ff;
               pool_in = 1'b1;
               pend_in.status = ppc_pkg::STATUS_OK;
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_LK_RD;
            end
         end
         ST_CH_MOD: begin
            if (rem_rsp.done) begin
               hops_in = rem_rsp.rem;
               state_in = ST_CH_RD;
            end
         end
         ST_CH_RD: begin
            if (hops_ff == '0) begin
               pend_in.end_index = p_ff;
               pend_in.status = ppc_pkg::STATUS_OK;
               state_in = ST_OUT;
            end else begin
               state_in = ST_CH_WT;
            end
         end
         ST_CH_WT: begin
            p_in = nxt_rd_ff;
            hops_in = hops_ff - 1'b1;
            state_in = ST_CH_RD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = pend_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_wa] <= ord_wd;
      end
      ord_rda_ff <= ord_mem[ord_ra];
      ord_rdb_ff <= ord_mem[ord_rb];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         nxt_mem[nxt_wa] <= nxt_wd;
      end
      nxt_rd_ff <= nxt_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seed_ff <= '0;
         count_cfg_ff <= ppc_pkg::NODE_COUNT_RESET;
         built_ff <= '0;
         pool_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff <= seed_in;
         count_cfg_ff <= count_cfg_in;
         built_ff <= built_in;
         pool_ff <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      idx_ff <= idx_in;
      j_ff <= j_in;
      tmp_ff <= tmp_in;
      p_ff <= p_in;
      hops_ff <= hops_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/ppc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module ppc_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input ppc_pkg::req_type             req_data,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input ppc_pkg::rsp_type             rsp_data,
   input wire                          csr_we,
   input wire [ppc_pkg::CSR_IDX_W-1:0] csr_index,
   input wire [63:0]                   csr_wdata
);
   `PPC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")
   `PPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")
   `PPC_ASSERT(a_build_zero, clock, reset, rsp_valid && rsp_data.was_build |-> rsp_data.end_index == '0, "build result carries an index")
   `PPC_ASSERT(a_err_zero, clock, reset, rsp_valid && rsp_data.status |-> rsp_data.end_index == '0, "failed request carries an index")
   `PPC_ASSERT(a_one_pending, clock, reset, req_valid && req_ready |=> !req_ready, "second request taken while busy")
endmodule

bind permutation_pool_pointer_chaser ppc_checker u_ppc_checker (.*);
`default_nettype wire
